// File: hdl/bcd_pkg.sv
// Shared widths, codes and control structs of the block cache directory.
package bcd_pkg;

   // Request payload widths
   localparam int FUNC_W    = 2;
   localparam int ADDR_W    = 32;
   localparam int FILL_W    = 10;

   // Response payload widths
   localparam int STATUS_W  = 3;
   localparam int INDEX_W   = 6;
   localparam int OFFSET_W  = 9;
   localparam int TAG_W     = 23;
   localparam int VBYTES_W  = 10;
   localparam int TOTAL_W   = 32;

   // Parameter defaults
   localparam int ENTRIES_DEF      = 64;
   localparam int BLOCK_BYTES_DEF  = 512;
   localparam int ADDRESS_BITS_DEF = 32;

   // Request functions
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FILL   = 2'd1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISS      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FILL_OK   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FILL_FAIL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FLUSHED   = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic emit_hit;
      logic tree_load;
      logic tree_step;
      logic install;
      logic fill;
      logic flush;
   } bcd_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic hit;
   } bcd_stat_type;

endpackage

// File: hdl/bcd_chan_if.sv
// Valid/ready channel interfaces for directory requests and responses.
interface bcd_req_if import bcd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ADDR_W-1:0] byte_address;
   logic [FILL_W-1:0] fill_count;

   modport source (output valid, output func, output byte_address, output fill_count,
                   input ready);
   modport sink   (input valid, input func, input byte_address, input fill_count,
                   output ready);
endinterface

interface bcd_rsp_if import bcd_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  entry_index;
   logic [OFFSET_W-1:0] block_offset;
   logic [TAG_W-1:0]    block_tag;
   logic [VBYTES_W-1:0] entry_valid_bytes;
   logic [TOTAL_W-1:0]  hits_total;
   logic [TOTAL_W-1:0]  misses_total;

   modport source (output valid, output status, output entry_index, output block_offset,
                   output block_tag, output entry_valid_bytes, output hits_total,
                   output misses_total, input ready);
   modport sink   (input valid, input status, input entry_index, input block_offset,
                   input block_tag, input entry_valid_bytes, input hits_total,
                   input misses_total, output ready);
endinterface

// File: hdl/block_cache_directory.sv
// Sequence: a lookup that hits responds from the lookup state; a miss walks the victim
// tree one level per cycle, then installs; fills and flushes respond from their state.
// Each response waits for a free response register. One request is in work at a time,
// and the next is accepted while the last response waits in its register.
// Reset (synchronous, active high) invalidates every entry at once, clears the counters,
// the pending fill and the response valid; no clearing pass is needed.
module block_cache_directory import bcd_pkg::*; #(
   parameter int ENTRIES      = ENTRIES_DEF,
   parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   bcd_req_if.sink    req_port,
   bcd_rsp_if.source  rsp_port
);

   // Control and datapath talk only through these two structs.
   bcd_cmd_type  cmd;
   bcd_stat_type stat;

   // Sequencer: accepts a request in idle, then walks it through
   // lookup -> (hit response | victim tree -> install), fill or flush.
   bcd_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_func  (req_port.func),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: tags and byte counts held in flops so every entry is compared
   // in parallel; each valid tag lives in one entry only, so the search start
   // point does not change the result. The victim is the lowest invalid entry,
   // else the lowest-index entry holding the smallest tag.
   bcd_datapath #(
      .ENTRIES      (ENTRIES),
      .BLOCK_BYTES  (BLOCK_BYTES),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_byte_address      (req_port.byte_address),
      .req_fill_count        (req_port.fill_count),
      .rsp_status            (rsp_port.status),
      .rsp_entry_index       (rsp_port.entry_index),
      .rsp_block_offset      (rsp_port.block_offset),
      .rsp_block_tag         (rsp_port.block_tag),
      .rsp_entry_valid_bytes (rsp_port.entry_valid_bytes),
      .rsp_hits_total        (rsp_port.hits_total),
      .rsp_misses_total      (rsp_port.misses_total)
   );

endmodule

// File: hdl/bcd_victim.sv
// Registered min-key reduction tree that picks the replacement entry.
module bcd_victim #(
   parameter int ENTRIES = 64,
   parameter int ETAG_W  = 23
) (
   input  logic                       clock,
   input  logic                       load,
   input  logic                       step,
   input  logic [ETAG_W-1:0]          ent_tag [ENTRIES],
   input  logic [ENTRIES-1:0]         ent_valid,
   output logic [$clog2(ENTRIES)-1:0] victim
);
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int PAD    = 1 << IDX_W;
   localparam int KEY_W  = ETAG_W + 1;

   // key = {valid, tag}; invalid entries rank lowest, padding highest
   logic [KEY_W-1:0] key_ff [PAD];
   logic [KEY_W-1:0] key_in [PAD];
   logic [IDX_W-1:0] idx_ff [PAD];
   logic [IDX_W-1:0] idx_in [PAD];

   always_comb begin
      for (int i = 0; i < PAD; i++) begin
         key_in[i] = key_ff[i];
         idx_in[i] = idx_ff[i];
      end
      if (load) begin
         for (int i = 0; i < PAD; i++) begin
            if (i < ENTRIES) begin
               key_in[i] = ent_valid[i] ? {1'b1, ent_tag[i]} : '0;
            end else begin
               key_in[i] = '1;
            end
            idx_in[i] = IDX_W'(i);
         end
      end else if (step) begin
         // pairwise halving; the left (lower index) wins a tie
         for (int j = 0; j < PAD / 2; j++) begin
            if (key_ff[2*j+1] < key_ff[2*j]) begin
               key_in[j] = key_ff[2*j+1];
               idx_in[j] = idx_ff[2*j+1];
            end else begin
               key_in[j] = key_ff[2*j];
               idx_in[j] = idx_ff[2*j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PAD; i++) begin
         key_ff[i] <= key_in[i];
         idx_ff[i] <= idx_in[i];
      end
   end

   assign victim = idx_ff[0];

endmodule

// File: hdl/bcd_datapath.sv
// Entry store, parallel tag match, counters and response register.
module bcd_datapath import bcd_pkg::*; #(
   parameter int ENTRIES      = ENTRIES_DEF,
   parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  bcd_cmd_type         cmd,
   output bcd_stat_type        stat,
   input  logic [ADDR_W-1:0]   req_byte_address,
   input  logic [FILL_W-1:0]   req_fill_count,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [INDEX_W-1:0]  rsp_entry_index,
   output logic [OFFSET_W-1:0] rsp_block_offset,
   output logic [TAG_W-1:0]    rsp_block_tag,
   output logic [VBYTES_W-1:0] rsp_entry_valid_bytes,
   output logic [TOTAL_W-1:0]  rsp_hits_total,
   output logic [TOTAL_W-1:0]  rsp_misses_total
);
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int OFF_W  = $clog2(BLOCK_BYTES);
   localparam int EFF_AW = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
   localparam int ETAG_W = EFF_AW - OFF_W;
   localparam int ECNT_W = $clog2(BLOCK_BYTES + 1);
   localparam int SAT_W  = 16;

   // captured request
   logic [ETAG_W-1:0] req_tag_ff, req_tag_in;
   logic [OFF_W-1:0]  req_off_ff, req_off_in;
   logic [FILL_W-1:0] req_fill_ff, req_fill_in;

   // entry store; a zero byte count marks an invalid entry
   logic [ETAG_W-1:0]  ent_tag_ff [ENTRIES];
   logic [ECNT_W-1:0]  ent_cnt_ff [ENTRIES];
   logic [ENTRIES-1:0] ent_valid;
   logic [ENTRIES-1:0] match;

   logic [IDX_W-1:0]  pend_idx_ff;
   logic              pend_valid_ff;
   logic [ETAG_W-1:0] pend_tag_ff;

   logic [TOTAL_W-1:0] hit_cnt_ff;
   logic [TOTAL_W-1:0] miss_cnt_ff;

   logic [STATUS_W-1:0] out_status_ff;
   logic [INDEX_W-1:0]  out_index_ff;
   logic [OFFSET_W-1:0] out_offset_ff;
   logic [TAG_W-1:0]    out_tag_ff;
   logic [VBYTES_W-1:0] out_vbytes_ff;

   logic [IDX_W-1:0]  hit_idx;
   logic [ECNT_W-1:0] hit_bytes;
   logic [IDX_W-1:0]  victim;
   logic [ECNT_W-1:0] fill_sat;

   assign req_tag_in  = req_byte_address[EFF_AW-1:OFF_W];
   assign req_off_in  = req_byte_address[OFF_W-1:0];
   assign req_fill_in = req_fill_count;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_tag_ff  <= req_tag_in;
         req_off_ff  <= req_off_in;
         req_fill_ff <= req_fill_in;
      end
   end

   // a tag is valid in at most one entry, so the match is one-hot
   for (genvar g = 0; g < ENTRIES; g++) begin : g_match
      assign ent_valid[g] = (ent_cnt_ff[g] != '0);
      assign match[g]     = ent_valid[g] && (ent_tag_ff[g] == req_tag_ff);
   end

   always_comb begin
      hit_idx   = '0;
      hit_bytes = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match[i]) begin
            hit_idx   = hit_idx | IDX_W'(i);
            hit_bytes = hit_bytes | ent_cnt_ff[i];
         end
      end
   end

   assign stat.hit = |match;

   always_comb begin
      if (SAT_W'(req_fill_ff) > SAT_W'(BLOCK_BYTES)) begin
         fill_sat = ECNT_W'(BLOCK_BYTES);
      end else begin
         fill_sat = ECNT_W'(req_fill_ff);
      end
   end

   bcd_victim #(
      .ENTRIES (ENTRIES),
      .ETAG_W  (ETAG_W)
   ) u_victim (
      .clock     (clock),
      .load      (cmd.tree_load),
      .step      (cmd.tree_step),
      .ent_tag   (ent_tag_ff),
      .ent_valid (ent_valid),
      .victim    (victim)
   );

   always_ff @(posedge clock) begin
      if (reset || cmd.flush) begin
         for (int i = 0; i < ENTRIES; i++) begin
            ent_cnt_ff[i] <= '0;
         end
      end else if (cmd.install) begin
         ent_cnt_ff[victim] <= '0;
      end else if (cmd.fill && pend_valid_ff) begin
         ent_cnt_ff[pend_idx_ff] <= fill_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.install) begin
         ent_tag_ff[victim] <= req_tag_ff;
         pend_tag_ff        <= req_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_idx_ff   <= '0;
         pend_valid_ff <= 1'b0;
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
      end else begin
         if (cmd.install) begin
            pend_idx_ff   <= victim;
            pend_valid_ff <= 1'b1;
         end else if (cmd.fill || cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.emit_hit && hit_cnt_ff != '1) begin
            hit_cnt_ff <= hit_cnt_ff + 1'b1;
         end
         if (cmd.install && miss_cnt_ff != '1) begin
            miss_cnt_ff <= miss_cnt_ff + 1'b1;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.emit_hit) begin
         out_status_ff <= ST_HIT;
         out_index_ff  <= INDEX_W'(hit_idx);
         out_offset_ff <= OFFSET_W'(req_off_ff);
         out_tag_ff    <= TAG_W'(req_tag_ff);
         out_vbytes_ff <= VBYTES_W'(hit_bytes);
      end else if (cmd.install) begin
         out_status_ff <= ST_MISS;
         out_index_ff  <= INDEX_W'(victim);
         out_offset_ff <= OFFSET_W'(req_off_ff);
         out_tag_ff    <= TAG_W'(req_tag_ff);
         out_vbytes_ff <= '0;
      end else if (cmd.fill) begin
         out_index_ff  <= INDEX_W'(pend_idx_ff);
         out_offset_ff <= '0;
         if (!pend_valid_ff) begin
            out_status_ff <= ST_FILL_FAIL;
            out_tag_ff    <= '0;
            out_vbytes_ff <= '0;
         end else if (fill_sat == '0) begin
            out_status_ff <= ST_FILL_FAIL;
            out_tag_ff    <= TAG_W'(pend_tag_ff);
            out_vbytes_ff <= '0;
         end else begin
            out_status_ff <= ST_FILL_OK;
            out_tag_ff    <= TAG_W'(pend_tag_ff);
            out_vbytes_ff <= VBYTES_W'(fill_sat);
         end
      end else if (cmd.flush) begin
         out_status_ff <= ST_FLUSHED;
         out_index_ff  <= '0;
         out_offset_ff <= '0;
         out_tag_ff    <= '0;
         out_vbytes_ff <= '0;
      end
   end

   assign rsp_status            = out_status_ff;
   assign rsp_entry_index       = out_index_ff;
   assign rsp_block_offset      = out_offset_ff;
   assign rsp_block_tag         = out_tag_ff;
   assign rsp_entry_valid_bytes = out_vbytes_ff;
   // counters only move when a response is loaded, so they track it
   assign rsp_hits_total        = hit_cnt_ff;
   assign rsp_misses_total      = miss_cnt_ff;

endmodule

// File: hdl/bcd_ctrl.sv
// Request sequencer: handshakes, step count of the victim tree, commands.
module bcd_ctrl import bcd_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  bcd_stat_type      stat,
   output bcd_cmd_type       cmd
);
   localparam int STEPS  = $clog2(ENTRIES);
   localparam int STEP_W = $clog2(STEPS + 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LOOK    = 3'd1;
   localparam logic [2:0] S_TREE    = 3'd2;
   localparam logic [2:0] S_INSTALL = 3'd3;
   localparam logic [2:0] S_FILL    = 3'd4;
   localparam logic [2:0] S_FLUSH   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;
   logic              emit;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      emit      = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_func == FUNC_LOOKUP) begin
                  state_in = S_LOOK;
               end else if (req_func == FUNC_FILL) begin
                  state_in = S_FILL;
               end else begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_LOOK: begin
            if (stat.hit) begin
               if (slot_free) begin
                  cmd.emit_hit = 1'b1;
                  emit         = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.tree_load = 1'b1;
               step_in       = STEP_W'(STEPS);
               state_in      = S_TREE;
            end
         end
         S_TREE: begin
            cmd.tree_step = 1'b1;
            step_in       = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = S_INSTALL;
            end
         end
         S_INSTALL: begin
            if (slot_free) begin
               cmd.install = 1'b1;
               emit        = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_FILL: begin
            if (slot_free) begin
               cmd.fill = 1'b1;
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (slot_free) begin
               cmd.flush = 1'b1;
               emit      = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: verif/tb_block_cache_directory.sv
// Self-checking testbench for the block cache directory: directed table, then random traffic.
module tb_block_cache_directory import bcd_pkg::*;;

   // Func codes the package leaves out: 2 flushes, and 3 is decoded as a flush too.
   localparam logic [FUNC_W-1:0] FUNC_FLUSH    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

   // Idle cycles with no request or response accepted before the run is called hung.
   // Worst case is a miss behind a receiver stalling 74% of the time.
   localparam int STALL_LIMIT  = 4000;
   // Requests in each random phase; with the directed table, about 1650 in all.
   localparam int PHASE_ITEMS  = 545;
   // Tag pool a bit larger than the directory, so full-directory evictions happen.
   localparam int POOL_SIZE    = 80;
   // Cycles left after the last response; covers the miss latency with margin.
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] byte_address;
      logic [FILL_W-1:0] fill_count;
   } dir_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  entry_index;
      logic [OFFSET_W-1:0] block_offset;
      logic [TAG_W-1:0]    block_tag;
      logic [VBYTES_W-1:0] entry_valid_bytes;
      logic [TOTAL_W-1:0]  hits_total;
      logic [TOTAL_W-1:0]  misses_total;
   } dir_rsp_type;

   // One row of the directed table; known marks rows whose response is typed in.
   typedef struct packed {
      dir_req_type req;
      logic        known;
      dir_rsp_type rsp;
   } directed_row_type;

   logic clock;
   logic reset;

   bcd_req_if req_bus();
   bcd_rsp_if rsp_bus();

   block_cache_directory u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Shadow copy of the directory state
   logic [TAG_W-1:0]    dir_tags  [ENTRIES_DEF];
   logic [VBYTES_W-1:0] dir_bytes [ENTRIES_DEF];
   logic [INDEX_W-1:0]  dir_hint;
   logic [INDEX_W-1:0]  fill_slot;
   logic                fill_waiting;
   logic [TOTAL_W-1:0]  dir_hits;
   logic [TOTAL_W-1:0]  dir_misses;

   dir_rsp_type      awaited_rsps[$];
   directed_row_type directed_rows[$];
   logic [TAG_W-1:0] tag_pool[POOL_SIZE];
   logic [STATUS_W-1:0] last_status;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned mismatch_count;
   int unsigned quiet_cycles;

   // Coverage tallies for the closing summary
   int unsigned requests_sent;
   int unsigned hits_seen;
   int unsigned misses_seen;
   int unsigned valid_evictions;
   int unsigned fills_good;
   int unsigned fills_failed;
   int unsigned flushes_seen;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void clear_directory();
      for (int k = 0; k < ENTRIES_DEF; k++) begin
         dir_tags[k]  = '0;
         dir_bytes[k] = '0;
      end
      dir_hint = '0;
      fill_waiting = 1'b0;
   endfunction

   // Advance the shadow directory by one request and return the response it owes.
   function automatic dir_rsp_type apply_request(input dir_req_type r);
      dir_rsp_type rsp;
      logic [TAG_W-1:0]    tag;
      logic [OFFSET_W-1:0] offs;
      logic [FILL_W-1:0]   cnt;
      int unsigned slot;
      int unsigned victim;
      bit found;
      bit have_free;
      rsp = '0;
      found = 1'b0;
      have_free = 1'b0;
      slot = 0;
      victim = 0;
      case (r.func)
         FUNC_LOOKUP: begin
            tag  = TAG_W'(r.byte_address / BLOCK_BYTES_DEF);
            offs = OFFSET_W'(r.byte_address % BLOCK_BYTES_DEF);
            // Search starts at the hint and wraps round
            for (int k = 0; k < ENTRIES_DEF && !found; k++) begin
               slot = (dir_hint + k) % ENTRIES_DEF;
               if (dir_bytes[slot] != 0 && dir_tags[slot] == tag)
                  found = 1'b1;
            end
            if (found) begin
               if (dir_hits != '1)
                  dir_hits++;
               dir_hint = INDEX_W'(slot);
               hits_seen++;
               rsp.status            = ST_HIT;
               rsp.entry_index       = INDEX_W'(slot);
               rsp.block_offset      = offs;
               rsp.block_tag         = tag;
               rsp.entry_valid_bytes = dir_bytes[slot];
            end else begin
               if (dir_misses != '1)
                  dir_misses++;
               // First invalid entry wins; with none, the smallest tag, lowest index on a tie
               for (int k = 0; k < ENTRIES_DEF; k++) begin
                  if (!have_free) begin
                     if (dir_bytes[k] == 0) begin
                        victim = k;
                        have_free = 1'b1;
                     end else if (dir_tags[k] < dir_tags[victim]) begin
                        victim = k;
                     end
                  end
               end
               if (dir_bytes[victim] != 0)
                  valid_evictions++;
               misses_seen++;
               dir_tags[victim]  = tag;
               dir_bytes[victim] = '0;
               fill_slot    = INDEX_W'(victim);
               fill_waiting = 1'b1;
               rsp.status       = ST_MISS;
               rsp.entry_index  = INDEX_W'(victim);
               rsp.block_offset = offs;
               rsp.block_tag    = tag;
            end
         end
         FUNC_FILL: begin
            cnt = r.fill_count;
            rsp.entry_index = fill_slot;
            if (!fill_waiting) begin
               // Stray fill: nothing changes, all payload but the index is zero
               rsp.status = ST_FILL_FAIL;
               fills_failed++;
            end else begin
               fill_waiting = 1'b0;
               if (cnt > BLOCK_BYTES_DEF)
                  cnt = FILL_W'(BLOCK_BYTES_DEF);
               rsp.block_tag = dir_tags[fill_slot];
               if (cnt == 0) begin
                  dir_bytes[fill_slot] = '0;
                  rsp.status = ST_FILL_FAIL;
                  fills_failed++;
               end else begin
                  dir_bytes[fill_slot] = cnt;
                  dir_hint = fill_slot;
                  rsp.status = ST_FILL_OK;
                  rsp.entry_valid_bytes = cnt;
                  fills_good++;
               end
            end
         end
         default: begin
            clear_directory();
            rsp.status = ST_FLUSHED;
            flushes_seen++;
         end
      endcase
      rsp.hits_total   = dir_hits;
      rsp.misses_total = dir_misses;
      return rsp;
   endfunction

   task automatic add_row(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr,
                          input logic [FILL_W-1:0] fill, input logic known,
                          input logic [STATUS_W-1:0] st, input logic [INDEX_W-1:0] idx,
                          input logic [OFFSET_W-1:0] offs, input logic [TAG_W-1:0] tag,
                          input logic [VBYTES_W-1:0] vbytes);
      directed_row_type row;
      row = '0;
      row.req.func              = func;
      row.req.byte_address      = addr;
      row.req.fill_count        = fill;
      row.known                 = known;
      row.rsp.status            = st;
      row.rsp.entry_index       = idx;
      row.rsp.block_offset      = offs;
      row.rsp.block_tag         = tag;
      row.rsp.entry_valid_bytes = vbytes;
      directed_rows.push_back(row);
   endtask

   // Entered and left at a falling edge. Valid stays high into the next request
   // unless an idle gap is drawn, so it never drops and rises in one time step.
   task automatic send_request(input dir_req_type r, input logic known,
                               input dir_rsp_type typed_rsp);
      dir_rsp_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= r.func;
      req_bus.byte_address <= r.byte_address;
      req_bus.fill_count   <= r.fill_count;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      want = apply_request(r);
      last_status = want.status;
      // Typed-in rows replace the payload; the counters always come from the shadow copy
      if (known) begin
         want.status            = typed_rsp.status;
         want.entry_index       = typed_rsp.entry_index;
         want.block_offset      = typed_rsp.block_offset;
         want.block_tag         = typed_rsp.block_tag;
         want.entry_valid_bytes = typed_rsp.entry_valid_bytes;
      end
      awaited_rsps.push_back(want);
      requests_sent++;
      @(negedge clock);
   endtask

   // Mostly well-formed traffic: pool lookups, each miss usually followed by its fill.
   // The rest is random addresses, stray fills and the odd flush.
   task automatic run_random_phase(input int unsigned count);
      dir_req_type r;
      int unsigned sent;
      int unsigned pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(999);
         r.func         = FUNC_LOOKUP;
         r.byte_address = $urandom();
         r.fill_count   = FILL_W'($urandom_range(1023));
         if (pick < 820)
            r.byte_address = {tag_pool[$urandom_range(POOL_SIZE - 1)], OFFSET_W'($urandom())};
         else if (pick < 900)
            r.func = FUNC_LOOKUP;
         else if (pick < 996)
            r.func = FUNC_FILL;
         else if (pick < 998)
            r.func = FUNC_FLUSH;
         else
            r.func = FUNC_RESERVED;
         send_request(r, 1'b0, '0);
         sent++;
         if (last_status == ST_MISS && $urandom_range(9) != 0 && sent < count) begin
            r.func = FUNC_FILL;
            pick = $urandom_range(9);
            if (pick == 0)
               r.fill_count = '0;
            else if (pick == 1)
               r.fill_count = FILL_W'($urandom_range(1023, BLOCK_BYTES_DEF + 1));
            else
               r.fill_count = FILL_W'($urandom_range(BLOCK_BYTES_DEF, 1));
            send_request(r, 1'b0, '0);
            sent++;
         end
      end
   endtask

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Receiver: ready redrawn every falling edge
   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

   // Response checker: every accepted response against the oldest expectation
   always @(posedge clock) begin
      dir_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_rsps.size() == 0) begin
            $error("response with none expected: status %0d, entry %0d",
                   rsp_bus.status, rsp_bus.entry_index);
            mismatch_count++;
         end else begin
            want = awaited_rsps.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            check_field("entry_index", 32'(want.entry_index), 32'(rsp_bus.entry_index));
            check_field("block_offset", 32'(want.block_offset), 32'(rsp_bus.block_offset));
            check_field("block_tag", 32'(want.block_tag), 32'(rsp_bus.block_tag));
            check_field("entry_valid_bytes", 32'(want.entry_valid_bytes),
                        32'(rsp_bus.entry_valid_bytes));
            check_field("hits_total", want.hits_total, rsp_bus.hits_total);
            check_field("misses_total", want.misses_total, rsp_bus.misses_total);
         end
      end
   end

   // Watchdog: any accept on either channel resets the count
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("timeout: %0d cycles without a handshake, %0d responses outstanding",
                     STALL_LIMIT, awaited_rsps.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      directed_row_type row;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.func         = FUNC_LOOKUP;
      req_bus.byte_address = '0;
      req_bus.fill_count   = '0;
      rsp_bus.ready        = 1'b0;
      send_idle_pct  = 9;
      recv_idle_pct  = 74;
      mismatch_count = 0;
      quiet_cycles   = 0;
      requests_sent  = 0;
      hits_seen      = 0;
      misses_seen    = 0;
      valid_evictions = 0;
      fills_good     = 0;
      fills_failed   = 0;
      flushes_seen   = 0;
      last_status    = ST_HIT;
      clear_directory();
      fill_slot  = '0;
      dir_hits   = '0;
      dir_misses = '0;

      // Tag pool: both tag extremes plus random block numbers
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int k = 2; k < POOL_SIZE; k++)
         tag_pool[k] = TAG_W'($urandom());

      // Directed table, run straight after reset
      // fill with nothing pending reports the pending entry and zeros
      add_row(FUNC_FILL,     32'h0000_0000, 10'd100,  1, ST_FILL_FAIL, 0, 0,     0,         0);
      // lowest address misses into entry 0
      add_row(FUNC_LOOKUP,   32'h0000_0000, 10'd0,    1, ST_MISS,      0, 0,     0,         0);
      // count above a block saturates to the block size
      add_row(FUNC_FILL,     32'h0000_0000, 10'd1023, 1, ST_FILL_OK,   0, 0,     0,       512);
      add_row(FUNC_LOOKUP,   32'h0000_01FF, 10'd0,    1, ST_HIT,       0, 511,   0,       512);
      // highest address: top tag, top offset
      add_row(FUNC_LOOKUP,   32'hFFFF_FFFF, 10'd0,    1, ST_MISS,      1, 511, 23'h7FFFFF, 0);
      // second and third miss before any fill reuse the still invalid entry
      add_row(FUNC_LOOKUP,   32'hFFFF_FE00, 10'd0,    1, ST_MISS,      1, 0,   23'h7FFFFF, 0);
      add_row(FUNC_LOOKUP,   32'h0000_0400, 10'd0,    1, ST_MISS,      1, 0,     2,         0);
      // failed read leaves the entry invalid
      add_row(FUNC_FILL,     32'h0000_0000, 10'd0,    1, ST_FILL_FAIL, 1, 0,     2,         0);
      add_row(FUNC_FILL,     32'h0000_0000, 10'd5,    1, ST_FILL_FAIL, 1, 0,     0,         0);
      add_row(FUNC_LOOKUP,   32'hAAAA_AAAA, 10'd0,    1, ST_MISS,      1, 9'h0AA, 23'h555555, 0);
      add_row(FUNC_FILL,     32'h0000_0000, 10'd1,    1, ST_FILL_OK,   1, 0,   23'h555555, 1);
      add_row(FUNC_LOOKUP,   32'h5555_5555, 10'd0,    1, ST_MISS,      2, 9'h155, 23'h2AAAAA, 0);
      add_row(FUNC_FILL,     32'h0000_0000, 10'd512,  1, ST_FILL_OK,   2, 0,   23'h2AAAAA, 512);
      add_row(FUNC_LOOKUP,   32'hAAAA_AA00, 10'd0,    1, ST_HIT,       1, 0,   23'h555555, 1);
      // func 3 acts as a flush
      add_row(FUNC_RESERVED, 32'h0000_0000, 10'd0,    1, ST_FLUSHED,   0, 0,     0,         0);
      add_row(FUNC_LOOKUP,   32'h0000_01FF, 10'd0,    1, ST_MISS,      0, 511,   0,         0);
      // flush with a fill pending drops the pending miss
      add_row(FUNC_FLUSH,    32'h0000_0000, 10'd0,    1, ST_FLUSHED,   0, 0,     0,         0);
      add_row(FUNC_FILL,     32'h0000_0000, 10'd7,    1, ST_FILL_FAIL, 0, 0,     0,         0);
      // hint moves on fill and on hit; checked against the shadow copy
      add_row(FUNC_LOOKUP,   32'h0001_2345, 10'd0,    0, ST_HIT,       0, 0,     0,         0);
      add_row(FUNC_FILL,     32'h0000_0000, 10'd200,  0, ST_HIT,       0, 0,     0,         0);
      add_row(FUNC_LOOKUP,   32'h0001_234A, 10'd0,    0, ST_HIT,       0, 0,     0,         0);
      add_row(FUNC_LOOKUP,   32'h7FFF_FFFF, 10'd0,    0, ST_HIT,       0, 0,     0,         0);
      add_row(FUNC_FILL,     32'h0000_0000, 10'd513,  0, ST_HIT,       0, 0,     0,         0);
      add_row(FUNC_LOOKUP,   32'h0001_2200, 10'd0,    0, ST_HIT,       0, 0,     0,         0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Phase 1: sender idles lightly, receiver heavily
      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         send_request(row.req, row.known, row.rsp);
      end
      run_random_phase(PHASE_ITEMS);

      // Phase 2: roles swapped
      send_idle_pct = 74;
      recv_idle_pct = 9;
      run_random_phase(PHASE_ITEMS);

      // Phase 3: back to back, no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(PHASE_ITEMS);

      req_bus.valid <= 1'b0;
      while (awaited_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests: %0d hits, %0d misses, %0d of them evicting a valid entry",
               requests_sent, hits_seen, misses_seen, valid_evictions);
      $display("Fills: %0d accepted, %0d failed or stray; %0d flushes; %0d mismatches",
               fills_good, fills_failed, flushes_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
